FILE: hdl/bmh_pkg.sv
// Shared types and constants for the binary max-heap priority queue.
package bmh_pkg;

  localparam int unsigned DefaultDepth = 32;

  typedef enum logic [2:0] {
    MODE_INSERT   = 3'd0,
    MODE_EXTRACT  = 3'd1,
    MODE_INCREASE = 3'd2,
    MODE_DECREASE = 3'd3,
    MODE_DELETE   = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_EMPTY  = 3'd1,
    ST_FULL   = 3'd2,
    ST_INDEX  = 3'd3,
    ST_REJECT = 3'd4
  } status_e;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [31:0] key;
    logic [4:0]         index;
  } req_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [2:0]         status;
    logic [5:0]         count;
  } rsp_t;

endpackage

FILE: hdl/bmh_front.sv
// Request intake: a two-entry queue that holds requests until the heap engine takes them.
module bmh_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_stall_o,
  input  bmh_pkg::req_t req_i,
  output logic          fifo_valid_o,
  input  logic          fifo_pop_i,
  output bmh_pkg::req_t fifo_req_o
);

  bmh_pkg::req_t slot_q [2];
  logic          rd_q, rd_d, wr_q, wr_d;
  logic [1:0]    cnt_q, cnt_d;
  logic          push, pop;

  assign req_stall_o  = (cnt_q == 2'd2);
  assign push         = req_valid_i && !req_stall_o;
  assign pop          = fifo_pop_i && (cnt_q != 2'd0);
  assign fifo_valid_o = (cnt_q != 2'd0);
  assign fifo_req_o   = slot_q[rd_q];

  always_comb begin
    rd_d  = pop ? ~rd_q : rd_q;
    wr_d  = push ? ~wr_q : wr_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      rd_q  <= rd_d;
      wr_q  <= wr_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= req_i;
    end
  end

endmodule

FILE: hdl/bmh_engine.sv
// Heap engine: memory, entry count and sift sequencer for one request at a time.
module bmh_engine #(
  parameter int unsigned DEPTH = bmh_pkg::DefaultDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_pop_o,
  input  bmh_pkg::req_t req_i,
  output logic          rsp_valid_o,
  input  logic          rsp_stall_i,
  output bmh_pkg::rsp_t rsp_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_RD0   = 11'b00000000010,
    S_CHK   = 11'b00000000100,
    S_MOVE  = 11'b00000001000,
    S_UPRD  = 11'b00000010000,
    S_UPCMP = 11'b00000100000,
    S_DNRD  = 11'b00001000000,
    S_DNR   = 11'b00010000000,
    S_DNCMP = 11'b00100000000,
    S_SWAP  = 11'b01000000000,
    S_DONE  = 11'b10000000000
  } state_e;

  state_e state_q, state_d;

  logic signed [31:0] mem_q [DEPTH];
  logic signed [31:0] rdata_q;
  logic [AW-1:0]      raddr;
  logic               rd_en;
  logic [AW-1:0]      waddr;
  logic signed [31:0] wdata;
  logic               we;

  logic [CW-1:0]      cnt_q, cnt_d;
  bmh_pkg::req_t      cur_q, cur_d;
  logic [AW-1:0]      pos_q, pos_d;
  logic [AW-1:0]      oth_q, oth_d;
  logic signed [31:0] pv_q, pv_d;
  logic signed [31:0] bv_q, bv_d;
  logic [AW-1:0]      ba_q, ba_d;
  logic               both_q, both_d;
  logic               out_v_q, out_v_d;
  bmh_pkg::rsp_t      out_q, out_d;

  logic [CW:0]  lft, rgt;
  logic         idx_ok;

  assign lft       = (CW+1)'({pos_q, 1'b1});
  assign rgt       = (CW+1)'({pos_q, 1'b0}) + (CW+1)'(2);
  assign idx_ok    = ({{CW{1'b0}}, cur_q.index} < {5'd0, cnt_q});
  assign req_pop_o = (state_q == S_IDLE) && req_valid_i && !out_v_q;
  assign rsp_valid_o = out_v_q;
  assign rsp_o     = out_q;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cur_d   = cur_q;
    pos_d   = pos_q;
    oth_d   = oth_q;
    pv_d    = pv_q;
    bv_d    = bv_q;
    ba_d    = ba_q;
    both_d  = both_q;
    out_v_d = out_v_q && rsp_stall_i;
    out_d   = out_q;
    raddr   = '0;
    rd_en   = 1'b0;
    waddr   = '0;
    wdata   = '0;
    we      = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (req_pop_o) begin
          cur_d        = req_i;
          out_d.value  = '0;
          out_d.status = bmh_pkg::ST_OK;
          state_d      = S_CHK;
        end
      end
      S_CHK: begin
        case (cur_q.mode)
          bmh_pkg::MODE_INSERT: begin
            if (cnt_q == CW'(DEPTH)) begin
              out_d.status = bmh_pkg::ST_FULL;
              state_d      = S_DONE;
            end else begin
              waddr   = cnt_q[AW-1:0];
              wdata   = cur_q.key;
              we      = 1'b1;
              pos_d   = cnt_q[AW-1:0];
              pv_d    = cur_q.key;
              cnt_d   = cnt_q + CW'(1);
              both_d  = 1'b0;
              state_d = S_UPRD;
            end
          end
          bmh_pkg::MODE_EXTRACT, bmh_pkg::MODE_INCREASE,
          bmh_pkg::MODE_DECREASE, bmh_pkg::MODE_DELETE: begin
            if (cnt_q == '0) begin
              out_d.status = bmh_pkg::ST_EMPTY;
              state_d      = S_DONE;
            end else if (cur_q.mode != bmh_pkg::MODE_EXTRACT && !idx_ok) begin
              out_d.status = bmh_pkg::ST_INDEX;
              state_d      = S_DONE;
            end else begin
              pos_d   = (cur_q.mode == bmh_pkg::MODE_EXTRACT) ? '0 : AW'(cur_q.index);
              raddr   = (cur_q.mode == bmh_pkg::MODE_EXTRACT) ? '0 : AW'(cur_q.index);
              rd_en   = 1'b1;
              state_d = S_RD0;
            end
          end
          default: state_d = S_DONE;
        endcase
      end
      S_RD0: begin
        case (cur_q.mode)
          bmh_pkg::MODE_INCREASE: begin
            if (rdata_q > cur_q.key) begin
              out_d.status = bmh_pkg::ST_REJECT;
              state_d      = S_DONE;
            end else begin
              waddr = pos_q; wdata = cur_q.key; we = 1'b1;
              pv_d = cur_q.key; both_d = 1'b0; state_d = S_UPRD;
            end
          end
          bmh_pkg::MODE_DECREASE: begin
            if (rdata_q < cur_q.key) begin
              out_d.status = bmh_pkg::ST_REJECT;
              state_d      = S_DONE;
            end else begin
              waddr = pos_q; wdata = cur_q.key; we = 1'b1;
              pv_d = cur_q.key; state_d = S_DNRD;
            end
          end
          default: begin
            out_d.value = rdata_q;
            cnt_d       = cnt_q - CW'(1);
            raddr       = cnt_d[AW-1:0];
            rd_en       = 1'b1;
            if (CW'(pos_q) == cnt_d) begin
              state_d = S_DONE;
            end else begin
              state_d = S_MOVE;
            end
          end
        endcase
      end
      S_MOVE: begin
        waddr  = pos_q; wdata = rdata_q; we = 1'b1;
        pv_d   = rdata_q;
        both_d = (cur_q.mode == bmh_pkg::MODE_DELETE);
        oth_d  = pos_q;
        state_d = (cur_q.mode == bmh_pkg::MODE_DELETE) ? S_UPRD : S_DNRD;
      end
      S_UPRD: begin
        if (pos_q == '0) begin
          state_d = both_q ? S_DNRD : S_DONE;
          pos_d   = both_q ? oth_q : pos_q;
        end else begin
          raddr   = (pos_q - AW'(1)) >> 1;
          rd_en   = 1'b1;
          state_d = S_UPCMP;
        end
      end
      S_UPCMP: begin
        if (rdata_q >= pv_q) begin
          state_d = both_q ? S_DNRD : S_DONE;
          pos_d   = both_q ? oth_q : pos_q;
        end else begin
          waddr   = pos_q; wdata = rdata_q; we = 1'b1;
          ba_d    = (pos_q - AW'(1)) >> 1;
          pos_d   = (pos_q - AW'(1)) >> 1;
          oth_d   = (pos_q - AW'(1)) >> 1;
          both_d  = 1'b0;
          state_d = S_SWAP;
        end
      end
      S_DNRD: begin
        if (lft < {1'b0, cnt_q}) begin
          raddr   = lft[AW-1:0];
          rd_en   = 1'b1;
          state_d = S_DNR;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DNR: begin
        bv_d = pv_q; ba_d = pos_q;
        if (rdata_q > pv_q) begin
          bv_d = rdata_q; ba_d = lft[AW-1:0];
        end
        if (rgt < {1'b0, cnt_q}) begin
          raddr   = rgt[AW-1:0];
          rd_en   = 1'b1;
          state_d = S_DNCMP;
        end else begin
          state_d = S_DNCMP;
        end
      end
      S_DNCMP: begin
        if (rgt < {1'b0, cnt_q} && rdata_q > bv_q) begin
          bv_d = rdata_q; ba_d = rgt[AW-1:0];
        end
        if ((rgt < {1'b0, cnt_q} && rdata_q > bv_q) || ba_q != pos_q) begin
          waddr   = pos_q;
          wdata   = (rgt < {1'b0, cnt_q} && rdata_q > bv_q) ? rdata_q : bv_q;
          we      = 1'b1;
          pos_d   = (rgt < {1'b0, cnt_q} && rdata_q > bv_q) ? rgt[AW-1:0] : ba_q;
          oth_d   = pos_q;
          state_d = S_SWAP;
        end else begin
          state_d = S_DONE;
        end
      end
      S_SWAP: begin
        waddr = pos_q; wdata = pv_q; we = 1'b1;
        state_d = (ba_q == pos_q && oth_q != pos_q) ? S_DNRD : S_UPRD;
        if (bv_q == pv_q && ba_q == pos_q) state_d = S_UPRD;
      end
      S_DONE: begin
        if (!out_v_q || !rsp_stall_i) begin
          out_v_d     = 1'b1;
          out_d.count = 6'(cnt_q);
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    pos_q  <= pos_d;
    oth_q  <= oth_d;
    pv_q   <= pv_d;
    bv_q   <= bv_d;
    ba_q   <= ba_d;
    both_q <= both_d;
    out_q  <= out_d;
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= (we && waddr == raddr) ? wdata : mem_q[raddr];
    end
  end

endmodule

FILE: hdl/binary_max_heap_priority_queue_core.sv
// Top level of the binary max-heap priority queue.
//
// Requests enter on req_valid_i / req_stall_o with a req_t payload (mode,
// key, index). Each request yields exactly one response on rsp_valid_o /
// rsp_stall_i carrying value, status and the entry count afterwards.
// A two-entry request queue takes requests while the engine works, so the
// sender sees a stall only once two requests wait.
// The engine handles one request at a time in a single-port memory of
// DEPTH keys: S_CHK and S_RD0 for checks and the first read, S_MOVE to
// move the last entry for extract or delete, then S_UPRD, S_UPCMP and
// S_SWAP per level of a sift up and S_DNRD, S_DNR, S_DNCMP and S_SWAP per
// level of a sift down. Delete first tries a sift up and sifts down only
// if the entry did not move up.
// The engine takes the next request only after its response is accepted.
// Reset empties the heap and the queue; memory contents are not cleared.
// While rsp_stall_i is high the response is held and the engine waits.
module binary_max_heap_priority_queue_core #(
  parameter int unsigned DEPTH = bmh_pkg::DefaultDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_stall_o,
  input  bmh_pkg::req_t req_i,
  output logic          rsp_valid_o,
  input  logic          rsp_stall_i,
  output bmh_pkg::rsp_t rsp_o
);

  logic          q_valid;
  logic          q_pop;
  bmh_pkg::req_t q_req;

  bmh_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_valid_i),
    .req_stall_o  (req_stall_o),
    .req_i        (req_i),
    .fifo_valid_o (q_valid),
    .fifo_pop_i   (q_pop),
    .fifo_req_o   (q_req)
  );

  bmh_engine #(.DEPTH(DEPTH)) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (q_valid),
    .req_pop_o   (q_pop),
    .req_i       (q_req),
    .rsp_valid_o (rsp_valid_o),
    .rsp_stall_i (rsp_stall_i),
    .rsp_o       (rsp_o)
  );

endmodule

FILE: hdl/bmh_checker.sv
// Port-level checks on the heap core, bound to the top level.
module bmh_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          req_valid_i,
  input logic          req_stall_o,
  input logic          rsp_valid_o,
  input logic          rsp_stall_i,
  input bmh_pkg::rsp_t rsp_o
);

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_stall_i |=> rsp_valid_o && $stable(rsp_o))
    else $error("response changed while stalled");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> rsp_o.count <= 6'd32)
    else $error("count out of range");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> rsp_o.status <= bmh_pkg::ST_REJECT)
    else $error("bad status code");

  a_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_o.status != bmh_pkg::ST_OK |-> rsp_o.value == 32'sd0)
    else $error("value set on failed request");

  a_stall_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_stall_o && !req_valid_i |=> !req_stall_o)
    else $error("stall raised without a request");

endmodule

bind binary_max_heap_priority_queue_core bmh_checker u_bmh_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_valid_i),
  .req_stall_o (req_stall_o),
  .rsp_valid_o (rsp_valid_o),
  .rsp_stall_i (rsp_stall_i),
  .rsp_o       (rsp_o)
);
